/* sv/crs_pkg.sv */
// Shared types, constants and the basis weight function of the Catmull-Rom sampler.
// No dependencies; the front end, queue, back end and top files import this package.
package crs_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        JOB_SEG,
        JOB_SEG_END,
        JOB_PAIR,
        JOB_SINGLE
    } t_job_op;

    typedef enum logic [2:0] {
        PH_START,
        PH_SEG_A,
        PH_SEG_B,
        PH_HELD,
        PH_FINAL
    } t_phase;

    localparam int OP_W = $bits(t_job_op);

    // Basis weight k for sample s of n, in units of 1/(2*n^3).
    function automatic int crs_weight(input int n, input int s, input int k);
        int n2;
        int n3;
        int s2;
        int s3;
        int w;
        n2 = n * n;
        n3 = n2 * n;
        s2 = s * s;
        s3 = s2 * s;
        case (k)
            0:       w = -s * n2 + 2 * s2 * n - s3;
            1:       w = 2 * n3 - 5 * s2 * n + 3 * s3;
            2:       w = s * n2 + 4 * s2 * n - 3 * s3;
            default: w = -s2 * n + s3;
        endcase
        return w;
    endfunction

endpackage

/* sv/crs_if.sv */
// Valid/ready channel interfaces for the input points and the output samples.
// No dependencies.
interface crs_point_if #(parameter int COORD_BITS = 20);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_point;

    modport source(output valid, point_x, point_y, last_point, input ready);
    modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

interface crs_sample_if #(parameter int COORD_BITS = 20);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] sample_x;
    logic signed [COORD_BITS-1:0] sample_y;
    logic                         end_of_curve;

    modport source(output valid, sample_x, sample_y, end_of_curve, input ready);
    modport sink(input valid, sample_x, sample_y, end_of_curve, output ready);
endinterface

/* sv/crs_front.sv */
// Front end: accepts points, keeps the three point window and classifies each point into a job or no job.
// Depends on crs_pkg and crs_point_if.
module crs_front #(
    parameter int COORD_BITS = 20
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    crs_point_if.sink                               i_pt,
    input  logic                                    i_full,
    output logic                                    o_push,
    output logic [crs_pkg::OP_W+8*COORD_BITS-1:0]   o_job
);
    import crs_pkg::*;

    localparam int CB = COORD_BITS;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;
    localparam logic [1:0] SEEN_FULL = 2'd3;

    logic signed [CB-1:0] r_win_x [3];
    logic signed [CB-1:0] r_win_y [3];
    logic signed [CB-1:0] n_win_x [3];
    logic signed [CB-1:0] n_win_y [3];
    logic [1:0]           r_seen;
    logic [1:0]           n_seen;

    logic                 w_acc;
    logic                 w_has_job;
    t_job_op              w_op;
    logic signed [CB-1:0] w_px [4];
    logic signed [CB-1:0] w_py [4];

    assign i_pt.ready = !i_full;
    assign w_acc      = i_pt.valid && i_pt.ready;

    always_comb begin
        w_px[0] = (r_seen == SEEN_TWO) ? r_win_x[1] : r_win_x[0];
        w_py[0] = (r_seen == SEEN_TWO) ? r_win_y[1] : r_win_y[0];
        w_px[1] = r_win_x[1];
        w_py[1] = r_win_y[1];
        w_px[2] = r_win_x[2];
        w_py[2] = r_win_y[2];
        w_px[3] = i_pt.point_x;
        w_py[3] = i_pt.point_y;
        w_has_job = 1'b0;
        w_op      = JOB_SEG;
        if (r_seen >= SEEN_TWO) begin
            w_has_job = 1'b1;
            w_op      = i_pt.last_point ? JOB_SEG_END : JOB_SEG;
        end else if (i_pt.last_point) begin
            w_has_job = 1'b1;
            w_op      = (r_seen == SEEN_ONE) ? JOB_PAIR : JOB_SINGLE;
        end
    end

    assign o_push = w_acc && w_has_job;
    assign o_job  = {w_op, w_px[3], w_px[2], w_px[1], w_px[0],
                     w_py[3], w_py[2], w_py[1], w_py[0]};

    always_comb begin
        n_win_x = r_win_x;
        n_win_y = r_win_y;
        n_seen  = r_seen;
        if (w_acc) begin
            if (i_pt.last_point) begin
                for (int k = 0; k < 3; k++) begin
                    n_win_x[k] = '0;
                    n_win_y[k] = '0;
                end
                n_seen = '0;
            end else begin
                n_win_x[0] = r_win_x[1];
                n_win_x[1] = r_win_x[2];
                n_win_x[2] = i_pt.point_x;
                n_win_y[0] = r_win_y[1];
                n_win_y[1] = r_win_y[2];
                n_win_y[2] = i_pt.point_y;
                if (r_seen != SEEN_FULL) begin
                    n_seen = r_seen + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win_x[k] <= '0;
                r_win_y[k] <= '0;
            end
            r_seen <= '0;
        end else begin
            r_win_x <= n_win_x;
            r_win_y <= n_win_y;
            r_seen  <= n_seen;
        end
    end

endmodule

/* sv/crs_fifo.sv */
// Short job queue between the front end and the back end.
// Depends on crs_pkg for the queue depth.
module crs_fifo #(
    parameter int DATA_W = 162
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);
    import crs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("Job pushed into a full queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Job popped from an empty queue.");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("Queue fill count beyond its depth.");

endmodule

/* sv/crs_back.sv */
// Back end: sequences each job into samples and runs the weighted sum, rounding divider
// and saturation pipeline. Depends on crs_pkg and crs_sample_if.
module crs_back #(
    parameter int SUBSAMPLES = 12,
    parameter int COORD_BITS = 20
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic [crs_pkg::OP_W+8*COORD_BITS-1:0]   i_job,
    input  logic                                    i_empty,
    output logic                                    o_pop,
    crs_sample_if.source                            o_smp
);
    import crs_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int JOB_W = OP_W + 8 * CB;
    localparam int CNT_W = $clog2(SUBSAMPLES);
    localparam int TAB_N = 2 ** CNT_W;
    localparam int N3    = SUBSAMPLES * SUBSAMPLES * SUBSAMPLES;
    localparam int D     = 2 * N3;
    localparam int WB    = $clog2(D) + 2;
    localparam int PB    = CB + WB;
    localparam int QB    = CB + 2;
    localparam int NB    = $clog2(D) + QB;
    localparam int SB    = NB + 1;
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(SUBSAMPLES - 1);
    localparam logic signed [SB-1:0] ROUND_S = SB'(N3);
    localparam logic signed [SB-1:0] OFF_S   = SB'(D) <<< (QB - 1);
    localparam logic signed [QB:0]   BIAS    = signed'({2'b01, {(QB-1){1'b0}}});
    localparam logic signed [QB:0]   SAT_HI  = signed'({4'b0000, {(CB-1){1'b1}}});
    localparam logic signed [QB:0]   SAT_LO  = signed'({4'b1111, {(CB-1){1'b0}}});

    // Weight table.
    logic signed [WB-1:0] w_tab [TAB_N][4];

    for (genvar gs = 0; gs < TAB_N; gs++) begin : g_tab
        for (genvar gk = 0; gk < 4; gk++) begin : g_w
            if (gs < SUBSAMPLES) begin : g_used
                assign w_tab[gs][gk] = WB'(crs_weight(SUBSAMPLES, gs, gk));
            end else begin : g_unused
                assign w_tab[gs][gk] = '0;
            end
        end
    end

    // Sequencer.
    t_job_op              w_op;
    logic signed [CB-1:0] w_jx [4];
    logic signed [CB-1:0] w_jy [4];
    t_phase               r_phase;
    t_phase               n_phase;
    t_phase               w_start;
    t_phase               w_cur;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 w_cnt_last;
    logic                 w_adv;
    logic                 w_issue;
    logic signed [CB-1:0] w_sx [4];
    logic signed [CB-1:0] w_sy [4];
    logic [CNT_W-1:0]     w_s;
    logic                 w_end;
    logic                 r_out_vld;

    assign w_op = t_job_op'(i_job[JOB_W-1 -: OP_W]);

    for (genvar gk = 0; gk < 4; gk++) begin : g_unpack
        assign w_jx[gk] = i_job[(4 + gk) * CB +: CB];
        assign w_jy[gk] = i_job[gk * CB +: CB];
    end

    assign w_adv      = !r_out_vld || o_smp.ready;
    assign w_issue    = w_adv && !i_empty;
    assign w_cnt_last = (r_cnt == CNT_LAST);

    always_comb begin
        unique case (w_op) inside
            JOB_SEG, JOB_SEG_END: w_start = PH_SEG_A;
            JOB_PAIR:             w_start = PH_HELD;
            JOB_SINGLE:           w_start = PH_FINAL;
            default:              w_start = PH_FINAL;
        endcase
        w_cur = (r_phase == PH_START) ? w_start : r_phase;
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        if (w_issue) begin
            unique case (w_cur)
                PH_SEG_A: begin
                    if (w_cnt_last) begin
                        n_cnt   = '0;
                        n_phase = (w_op == JOB_SEG_END) ? PH_SEG_B : PH_START;
                    end else begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_phase = PH_SEG_A;
                    end
                end
                PH_SEG_B: begin
                    if (w_cnt_last) begin
                        n_cnt   = '0;
                        n_phase = PH_FINAL;
                    end else begin
                        n_cnt   = r_cnt + CNT_W'(1);
                        n_phase = PH_SEG_B;
                    end
                end
                PH_HELD:  n_phase = PH_FINAL;
                PH_FINAL: n_phase = PH_START;
                PH_START: n_phase = PH_START;
                default:  n_phase = PH_START;
            endcase
        end
    end

    always_comb begin
        w_sx  = w_jx;
        w_sy  = w_jy;
        w_s   = r_cnt;
        w_end = 1'b0;
        o_pop = 1'b0;
        unique case (w_cur)
            PH_SEG_A: begin
                o_pop = w_issue && w_cnt_last && (w_op != JOB_SEG_END);
            end
            PH_SEG_B: begin
                w_sx[0] = w_jx[1];
                w_sx[1] = w_jx[2];
                w_sx[2] = w_jx[3];
                w_sy[0] = w_jy[1];
                w_sy[1] = w_jy[2];
                w_sy[2] = w_jy[3];
            end
            PH_HELD: begin
                w_sx[1] = w_jx[2];
                w_sy[1] = w_jy[2];
                w_s     = '0;
            end
            PH_FINAL: begin
                w_sx[1] = w_jx[3];
                w_sy[1] = w_jy[3];
                w_s     = '0;
                w_end   = 1'b1;
                o_pop   = w_issue;
            end
            PH_START: begin
                w_s = r_cnt;
            end
            default: begin
                w_s = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath pipeline; every stage moves together when the output register can take a sample.
    logic                 r_a_vld;
    logic                 r_a_end;
    logic [CNT_W-1:0]     r_a_s;
    logic signed [CB-1:0] r_a_px [4];
    logic signed [CB-1:0] r_a_py [4];
    logic                 r_b_vld;
    logic                 r_b_end;
    logic signed [WB-1:0] r_b_w  [4];
    logic signed [CB-1:0] r_b_px [4];
    logic signed [CB-1:0] r_b_py [4];
    logic                 r_c_vld;
    logic                 r_c_end;
    logic signed [PB-1:0] r_c_prx [4];
    logic signed [PB-1:0] r_c_pry [4];
    logic                 r_d_vld;
    logic                 r_d_end;
    logic [NB-1:0]        r_d_nx;
    logic [NB-1:0]        r_d_ny;
    logic signed [SB-1:0] w_sum_x;
    logic signed [SB-1:0] w_sum_y;

    always_comb begin
        w_sum_x = ROUND_S + OFF_S;
        w_sum_y = ROUND_S + OFF_S;
        for (int k = 0; k < 4; k++) begin
            w_sum_x = w_sum_x + SB'(r_c_prx[k]);
            w_sum_y = w_sum_y + SB'(r_c_pry[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_end <= w_end;
            r_a_s   <= w_s;
            r_a_px  <= w_sx;
            r_a_py  <= w_sy;
            r_b_end <= r_a_end;
            r_b_px  <= r_a_px;
            r_b_py  <= r_a_py;
            for (int k = 0; k < 4; k++) begin
                r_b_w[k]   <= w_tab[r_a_s][k];
                r_c_prx[k] <= PB'(r_b_w[k]) * PB'(r_b_px[k]);
                r_c_pry[k] <= PB'(r_b_w[k]) * PB'(r_b_py[k]);
            end
            r_c_end <= r_b_end;
            r_d_end <= r_c_end;
            r_d_nx  <= NB'(w_sum_x);
            r_d_ny  <= NB'(w_sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= w_issue;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    // Division by the constant 2*N^3 as a multiply by its rounded-up reciprocal. The numerator
    // stays below 2^NB, so the shifted product equals the floor quotient exactly. The product is
    // built from two half-width partial products in one stage and summed in the next.
    localparam int KB = NB + $clog2(D);
    localparam int MB = NB + 2;
    localparam int ML = MB / 2;
    localparam int MH = MB - ML;
    localparam int PW = NB + MB;
    localparam logic [KB:0]   DEN_K    = (KB+1)'(D);
    localparam logic [KB:0]   RECIP    = (((KB+1)'(1) << KB) + DEN_K - (KB+1)'(1)) / DEN_K;
    localparam logic [ML-1:0] RECIP_LO = RECIP[ML-1:0];
    localparam logic [MH-1:0] RECIP_HI = RECIP[MB-1:ML];

    logic                 r_e_vld;
    logic                 r_e_end;
    logic [NB+ML-1:0]     r_e_lx;
    logic [NB+ML-1:0]     r_e_ly;
    logic [NB+MH-1:0]     r_e_hx;
    logic [NB+MH-1:0]     r_e_hy;
    logic [PW-1:0]        w_prod_x;
    logic [PW-1:0]        w_prod_y;
    logic                 r_f_vld;
    logic                 r_f_end;
    logic [QB-1:0]        r_f_qx;
    logic [QB-1:0]        r_f_qy;

    assign w_prod_x = {r_e_hx, {ML{1'b0}}} + PW'(r_e_lx);
    assign w_prod_y = {r_e_hy, {ML{1'b0}}} + PW'(r_e_ly);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_end <= r_d_end;
            r_e_lx  <= (NB+ML)'(r_d_nx) * (NB+ML)'(RECIP_LO);
            r_e_ly  <= (NB+ML)'(r_d_ny) * (NB+ML)'(RECIP_LO);
            r_e_hx  <= (NB+MH)'(r_d_nx) * (NB+MH)'(RECIP_HI);
            r_e_hy  <= (NB+MH)'(r_d_ny) * (NB+MH)'(RECIP_HI);
            r_f_end <= r_e_end;
            r_f_qx  <= w_prod_x[KB +: QB];
            r_f_qy  <= w_prod_y[KB +: QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    // Bias removal, saturation and the output register.
    logic signed [QB:0]   w_vx;
    logic signed [QB:0]   w_vy;
    logic signed [CB-1:0] w_ox;
    logic signed [CB-1:0] w_oy;
    logic signed [CB-1:0] r_out_x;
    logic signed [CB-1:0] r_out_y;
    logic                 r_out_end;

    assign w_vx = signed'({1'b0, r_f_qx}) - BIAS;
    assign w_vy = signed'({1'b0, r_f_qy}) - BIAS;

    always_comb begin
        if (w_vx > SAT_HI) begin
            w_ox = SAT_HI[CB-1:0];
        end else if (w_vx < SAT_LO) begin
            w_ox = SAT_LO[CB-1:0];
        end else begin
            w_ox = w_vx[CB-1:0];
        end
        if (w_vy > SAT_HI) begin
            w_oy = SAT_HI[CB-1:0];
        end else if (w_vy < SAT_LO) begin
            w_oy = SAT_LO[CB-1:0];
        end else begin
            w_oy = w_vy[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_x   <= w_ox;
            r_out_y   <= w_oy;
            r_out_end <= r_f_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_f_vld;
        end
    end

    assign o_smp.valid        = r_out_vld;
    assign o_smp.sample_x     = r_out_x;
    assign o_smp.sample_y     = r_out_y;
    assign o_smp.end_of_curve = r_out_end;

    a_pop_on_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> w_issue)
        else $error("Job retired without issuing its last sample.");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LAST)
        else $error("Sample counter beyond the segment length.");

    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START || r_phase == PH_HELD || r_phase == PH_FINAL)
            |-> (r_cnt == '0))
        else $error("Sample counter not cleared outside a segment.");

endmodule

/* sv/catmull_rom_curve_sampler_top.sv */
// Catmull-Rom curve sampler: a point stream in, uniform spline samples out. Each point that
// closes a segment yields SUBSAMPLES samples from the back end sequencer, one per cycle while
// the output takes them; a final point yields 2*SUBSAMPLES+1 results, and short series pass
// their points through. The input waits only when the two-entry job queue is full, so new
// points are taken while the back end still samples earlier jobs; a sample leaves through
// the weighting stages and the reciprocal multiply that divides by 2*N^3. There is no
// clearing pass.
// Depends on crs_pkg, crs_if, crs_front, crs_fifo and crs_back.
module catmull_rom_curve_sampler_top #(
    parameter int SUBSAMPLES = 12,
    parameter int COORD_BITS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    crs_point_if.sink     i_pt,
    crs_sample_if.source  o_smp
);
    import crs_pkg::*;

    localparam int JOB_W = OP_W + 8 * COORD_BITS;

    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;
    logic [JOB_W-1:0] w_job_in;
    logic [JOB_W-1:0] w_job_out;

    crs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (i_pt),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    crs_fifo #(
        .DATA_W (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    crs_back #(
        .SUBSAMPLES (SUBSAMPLES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_smp   (o_smp)
    );

endmodule
